/* rtl/core/tta_pkg.sv */
// shared types and constants for the tapered tilted aperture check
`timescale 1ns / 1ps
package tta_pkg;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_BITS      = 64;
  localparam int HALF_WORD     = 32;
  localparam int POS_BITS      = 32;
  localparam int Z_BITS        = 31;
  localparam int INV_BITS      = 49;
  localparam int INV_LO_BITS   = 25;
  localparam int F_BITS        = Z_BITS + INV_BITS;
  localparam int F_CHUNK       = 27;
  localparam int F_CHUNKS      = 3;
  localparam int TERM_BITS     = 57;
  localparam int WIDE_BITS     = TERM_BITS + 1;
  localparam int TRIG_BITS     = 32;
  localparam int ROT_LO_BITS   = 29;
  localparam int ROT_PROD_BITS = WIDE_BITS + TRIG_BITS;
  localparam int ROT_BITS      = ROT_PROD_BITS + 1;
  localparam int RESULT_LATENCY = 12;

  localparam logic [TERM_BITS-1:0] TERM_LIMIT = {1'b1, {(TERM_BITS-1){1'b0}}};
  localparam logic [CFG_BITS-1:0]  TILT_RESET = 64'h0000_0000_4000_0000;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILT       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_OFS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_OFS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_SIZE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_SIZE  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_LEN    = 3'd6;

  localparam logic [1:0] MODE_TAPERED = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_POS_JAW = 2'd2;
  localparam logic [1:0] MODE_NEG_JAW = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       diamond;
    logic [1:0] mode;
  } tta_ctl_t;
endpackage

/* rtl/core/tta_interp.sv */
// interpolation term: sign(d) * floor(f * |d| / 2^recip), saturated, three stages
`timescale 1ns / 1ps
module tta_interp #(
  parameter int DM_BITS         = 32,
  parameter int RECIP_FRAC_BITS = 48
) (
  input  logic                                   clk,
  input  logic [tta_pkg::F_BITS-1:0]             f,
  input  logic [DM_BITS-1:0]                     dm,
  input  logic                                   d_neg,
  output logic signed [tta_pkg::WIDE_BITS-1:0]   term
);
  import tta_pkg::*;

  localparam int PROD_BITS = F_CHUNK + DM_BITS;
  localparam int SUM_BITS  = F_BITS + DM_BITS;
  localparam int FPAD_BITS = F_CHUNK * F_CHUNKS;

  logic [FPAD_BITS-1:0] f_pad;
  logic [PROD_BITS-1:0] prod [F_CHUNKS];
  logic                 neg_p;
  logic                 neg_s;
  logic [SUM_BITS-1:0]  sum_c;
  logic [SUM_BITS-1:0]  quot_c;
  logic [TERM_BITS-1:0] mag;

  assign f_pad = FPAD_BITS'(f);

  // partial products of f against the difference magnitude
  always_ff @(posedge clk) begin
    for (int i = 0; i < F_CHUNKS; i++) begin
      prod[i] <= PROD_BITS'(f_pad[i*F_CHUNK +: F_CHUNK]) * PROD_BITS'(dm);
    end
    neg_p <= d_neg;
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < F_CHUNKS; i++) begin
      sum_c = sum_c + (SUM_BITS'(prod[i]) << (i * F_CHUNK));
    end
    quot_c = sum_c >> RECIP_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    mag   <= (quot_c > SUM_BITS'(TERM_LIMIT)) ? TERM_LIMIT : quot_c[TERM_BITS-1:0];
    neg_s <= neg_p;
  end

  always_ff @(posedge clk) begin
    term <= neg_s ? WIDE_BITS'(0) - {1'b0, mag} : {1'b0, mag};
  end
endmodule

/* rtl/core/tta_rotate.sv */
// rotation by the tilt and the jaw window tests, five stages
`timescale 1ns / 1ps
module tta_rotate #(
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tta_pkg::tta_ctl_t                    ctl_in,
  input  logic signed [tta_pkg::WIDE_BITS-1:0] u,
  input  logic signed [tta_pkg::WIDE_BITS-1:0] v,
  input  logic signed [tta_pkg::WIDE_BITS-1:0] w,
  input  logic signed [tta_pkg::WIDE_BITS-1:0] h,
  input  logic signed [tta_pkg::TRIG_BITS-1:0] cos_v,
  input  logic signed [tta_pkg::TRIG_BITS-1:0] sin_v,
  output logic                                 done,
  output logic                                 inside_res
);
  import tta_pkg::*;

  localparam int HI_BITS  = WIDE_BITS - ROT_LO_BITS;
  localparam int PH_BITS  = HI_BITS + TRIG_BITS;
  localparam int PL_BITS  = ROT_LO_BITS + 1 + TRIG_BITS;
  localparam int CMP_BITS = ROT_BITS + 1;

  logic signed [HI_BITS-1:0]     u_hi, v_hi;
  logic signed [ROT_LO_BITS:0]   u_lo, v_lo;

  logic signed [PH_BITS-1:0]     uc_hi, vs_hi, us_hi, vc_hi;
  logic signed [PL_BITS-1:0]     uc_lo, vs_lo, us_lo, vc_lo;
  logic signed [WIDE_BITS-1:0]   r1_w, r1_h, r2_w, r2_h, r3_w, r3_h;
  tta_ctl_t                      r1_ctl, r2_ctl, r3_ctl, r4_ctl;

  logic signed [ROT_PROD_BITS-1:0] uc, vs, us, vc;
  logic signed [ROT_BITS-1:0]      a_val, b_val;

  logic [ROT_BITS-1:0]  a_mag, b_mag;
  logic                 a_neg, a_pos;
  logic [CMP_BITS-1:0]  w_lim, h_lim;
  logic                 w_ok, h_ok;

  logic                 lt_a, fit_a, fit_b;

  assign u_hi = u[WIDE_BITS-1:ROT_LO_BITS];
  assign v_hi = v[WIDE_BITS-1:ROT_LO_BITS];
  assign u_lo = {1'b0, u[ROT_LO_BITS-1:0]};
  assign v_lo = {1'b0, v[ROT_LO_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_ctl <= '0;
      r2_ctl <= '0;
      r3_ctl <= '0;
      r4_ctl <= '0;
      done   <= 1'b0;
    end else begin
      r1_ctl <= ctl_in;
      r2_ctl <= r1_ctl;
      r3_ctl <= r2_ctl;
      r4_ctl <= r3_ctl;
      done   <= r4_ctl.valid;
    end
  end

  // split products
  always_ff @(posedge clk) begin
    uc_hi <= u_hi * cos_v;
    uc_lo <= u_lo * cos_v;
    vs_hi <= v_hi * sin_v;
    vs_lo <= v_lo * sin_v;
    us_hi <= u_hi * sin_v;
    us_lo <= u_lo * sin_v;
    vc_hi <= v_hi * cos_v;
    vc_lo <= v_lo * cos_v;
    r1_w  <= w;
    r1_h  <= h;
  end

  always_ff @(posedge clk) begin
    uc   <= (ROT_PROD_BITS'(uc_hi) <<< ROT_LO_BITS) + ROT_PROD_BITS'(uc_lo);
    vs   <= (ROT_PROD_BITS'(vs_hi) <<< ROT_LO_BITS) + ROT_PROD_BITS'(vs_lo);
    us   <= (ROT_PROD_BITS'(us_hi) <<< ROT_LO_BITS) + ROT_PROD_BITS'(us_lo);
    vc   <= (ROT_PROD_BITS'(vc_hi) <<< ROT_LO_BITS) + ROT_PROD_BITS'(vc_lo);
    r2_w <= r1_w;
    r2_h <= r1_h;
  end

  always_ff @(posedge clk) begin
    a_val <= ROT_BITS'(uc) - ROT_BITS'(vs);
    b_val <= ROT_BITS'(us) + ROT_BITS'(vc);
    r3_w  <= r2_w;
    r3_h  <= r2_h;
  end

  always_ff @(posedge clk) begin
    a_mag <= a_val[ROT_BITS-1] ? ROT_BITS'(0) - a_val : a_val;
    b_mag <= b_val[ROT_BITS-1] ? ROT_BITS'(0) - b_val : b_val;
    a_neg <= a_val[ROT_BITS-1];
    a_pos <= !a_val[ROT_BITS-1] && (a_val != '0);
    w_lim <= CMP_BITS'(r3_w) << TRIG_FRAC_BITS;
    h_lim <= CMP_BITS'(r3_h) << TRIG_FRAC_BITS;
    w_ok  <= !r3_w[WIDE_BITS-1] && (r3_w != '0);
    h_ok  <= !r3_h[WIDE_BITS-1] && (r3_h != '0);
  end

  always_comb begin
    lt_a  = w_ok && ({a_mag, 1'b0} < w_lim);
    fit_b = h_ok && ({b_mag, 1'b0} < h_lim);
    case (r4_ctl.mode)
      MODE_POS_JAW: fit_a = lt_a || a_neg;
      MODE_NEG_JAW: fit_a = lt_a || a_pos;
      default:      fit_a = lt_a;
    endcase
  end

  always_ff @(posedge clk) begin
    inside_res <= r4_ctl.diamond || (fit_a && fit_b);
  end
endmodule

/* rtl/core/tapered_tilted_aperture_check.sv */
// top level of the tapered tilted aperture check
//
// usage
//   a position word (pos_x, pos_y, pos_z) is taken at a rising edge with start
//   high and busy low; busy stays low, so a new word may be given every cycle
//   one result word per position: done is high for exactly one cycle with
//   inside_res valid, once the word has passed the input, length fraction,
//   interpolation, shift, rotation and compare registers, in input order
//   throughput is one word per cycle; the delay comes from the multiplier
//   stages (length interpolation, then the tilt rotation) and the window compare
//   the receiver cannot stall: done is a strobe and inside_res is only valid with it
//   registers are written over cfg_valid / cfg_ready / cfg_index / cfg_data,
//   cfg_ready is always high; write them only while no word is in flight
//   synchronous reset (rst) empties the pipeline and loads the register defaults:
//   tapered mode, zero tilt, zero offsets, sizes and inverse length
`timescale 1ns / 1ps
module tapered_tilted_aperture_check #(
  parameter int COORD_BITS      = 32,
  parameter int TRIG_FRAC_BITS  = 30,
  parameter int RECIP_FRAC_BITS = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [tta_pkg::POS_BITS-1:0]   pos_x,
  input  logic signed [tta_pkg::POS_BITS-1:0]   pos_y,
  input  logic [tta_pkg::Z_BITS-1:0]            pos_z,
  output logic                                  done,
  output logic                                  inside_res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tta_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tta_pkg::CFG_BITS-1:0]          cfg_data
);
  import tta_pkg::*;

  localparam int HB         = (COORD_BITS < HALF_WORD) ? COORD_BITS : HALF_WORD;
  localparam int DW         = HB + 1;
  localparam int AW         = POS_BITS + 1;
  localparam int DSUM_BITS  = POS_BITS + 3;
  localparam int N_TERMS    = 4;
  localparam int TERM_OX    = 0;
  localparam int TERM_OY    = 1;
  localparam int TERM_W     = 2;
  localparam int TERM_H     = 3;
  localparam int INTERP_LAT = 3;

  logic [1:0]            mode;
  logic [CFG_BITS-1:0]   tilt_cos_sin;
  logic [CFG_BITS-1:0]   entry_offsets;
  logic [CFG_BITS-1:0]   exit_offsets;
  logic [CFG_BITS-1:0]   entrance_size;
  logic [CFG_BITS-1:0]   exit_size;
  logic [INV_BITS-1:0]   inverse_length;

  logic signed [HB-1:0]  ex_h, ey_h, xx_h, xy_h;
  logic [HB-1:0]         wen_h, hen_h, wex_h, hex_h;
  logic [HB-1:0]         min_size;
  logic                  offsets_zero;
  logic [DW-1:0]         d_c   [N_TERMS];
  logic [DW-1:0]         d_mag [N_TERMS];

  logic                  s1_valid;
  logic signed [POS_BITS-1:0] s1_x, s1_y;
  logic [Z_BITS-1:0]     s1_z;

  logic [AW-1:0]         ax, ay;
  logic [POS_BITS+1:0]   pos_sum;
  logic                  diamond_c;

  logic                  s2_valid;
  logic [Z_BITS+INV_LO_BITS-1:0]            s2_fp_lo;
  logic [Z_BITS+INV_BITS-INV_LO_BITS-1:0]   s2_fp_hi;
  logic [HB-1:0]         s2_dm  [N_TERMS];
  logic                  s2_neg [N_TERMS];
  logic signed [POS_BITS-1:0] s2_x, s2_y;
  logic                  s2_diamond;

  logic                  s3_valid;
  logic [F_BITS-1:0]     s3_f;
  logic [HB-1:0]         s3_dm  [N_TERMS];
  logic                  s3_neg [N_TERMS];
  logic signed [POS_BITS-1:0] s3_x, s3_y;
  logic                  s3_diamond;

  logic [INTERP_LAT-1:0]      v_dly;
  logic [INTERP_LAT-1:0]      diamond_dly;
  logic signed [POS_BITS-1:0] x_dly [INTERP_LAT];
  logic signed [POS_BITS-1:0] y_dly [INTERP_LAT];
  logic signed [WIDE_BITS-1:0] term [N_TERMS];

  logic                  s7_valid;
  logic                  s7_diamond;
  logic signed [WIDE_BITS-1:0] s7_u, s7_v, s7_w, s7_h;
  tta_ctl_t              rot_ctl;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_TAPERED;
      tilt_cos_sin   <= TILT_RESET;
      entry_offsets  <= '0;
      exit_offsets   <= '0;
      entrance_size  <= '0;
      exit_size      <= '0;
      inverse_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       mode           <= cfg_data[1:0];
        REG_TILT:       tilt_cos_sin   <= cfg_data;
        REG_ENTRY_OFS:  entry_offsets  <= cfg_data;
        REG_EXIT_OFS:   exit_offsets   <= cfg_data;
        REG_ENTRY_SIZE: entrance_size  <= cfg_data;
        REG_EXIT_SIZE:  exit_size      <= cfg_data;
        REG_INV_LEN:    inverse_length <= cfg_data[INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ex_h  = entry_offsets[HB-1:0];
  assign ey_h  = entry_offsets[HALF_WORD +: HB];
  assign xx_h  = exit_offsets[HB-1:0];
  assign xy_h  = exit_offsets[HALF_WORD +: HB];
  assign wen_h = entrance_size[HB-1:0];
  assign hen_h = entrance_size[HALF_WORD +: HB];
  assign wex_h = exit_size[HB-1:0];
  assign hex_h = exit_size[HALF_WORD +: HB];

  assign d_c[TERM_OX] = {ex_h[HB-1], ex_h} - {xx_h[HB-1], xx_h};
  assign d_c[TERM_OY] = {ey_h[HB-1], ey_h} - {xy_h[HB-1], xy_h};
  assign d_c[TERM_W]  = {1'b0, wex_h} - {1'b0, wen_h};
  assign d_c[TERM_H]  = {1'b0, hex_h} - {1'b0, hen_h};

  always_comb begin
    for (int i = 0; i < N_TERMS; i++) begin
      d_mag[i] = d_c[i][HB] ? DW'(0) - d_c[i] : d_c[i];
    end
  end

  assign offsets_zero = (ex_h == '0) && (ey_h == '0) && (xx_h == '0) && (xy_h == '0);
  assign min_size     = (wen_h < hen_h) ? wen_h : hen_h;

  // diamond shortcut on the centred opening in tapered mode; the tilt is not checked
  assign ax        = s1_x[POS_BITS-1] ? AW'(0) - {1'b1, s1_x} : {1'b0, s1_x};
  assign ay        = s1_y[POS_BITS-1] ? AW'(0) - {1'b1, s1_y} : {1'b0, s1_y};
  assign pos_sum   = {1'b0, ax} + {1'b0, ay};
  assign diamond_c = (mode == MODE_TAPERED) && offsets_zero &&
                     ({pos_sum, 1'b0} < DSUM_BITS'(min_size));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      v_dly    <= '0;
      s7_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      v_dly    <= {v_dly[INTERP_LAT-2:0], s3_valid};
      s7_valid <= v_dly[INTERP_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_z <= pos_z;
    end
  end

  // length fraction partials and difference magnitudes
  always_ff @(posedge clk) begin
    s2_fp_lo <= s1_z * inverse_length[INV_LO_BITS-1:0];
    s2_fp_hi <= s1_z * inverse_length[INV_BITS-1:INV_LO_BITS];
    for (int i = 0; i < N_TERMS; i++) begin
      s2_dm[i]  <= (mode == MODE_TAPERED) ? d_mag[i][HB-1:0] : '0;
      s2_neg[i] <= d_c[i][HB];
    end
    s2_x       <= s1_x;
    s2_y       <= s1_y;
    s2_diamond <= diamond_c;
  end

  always_ff @(posedge clk) begin
    s3_f       <= F_BITS'(s2_fp_lo) + (F_BITS'(s2_fp_hi) << INV_LO_BITS);
    s3_dm      <= s2_dm;
    s3_neg     <= s2_neg;
    s3_x       <= s2_x;
    s3_y       <= s2_y;
    s3_diamond <= s2_diamond;
  end

  for (genvar g = 0; g < N_TERMS; g++) begin : g_interp
    tta_interp #(
      .DM_BITS         (HB),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_interp (
      .clk   (clk),
      .f     (s3_f),
      .dm    (s3_dm[g]),
      .d_neg (s3_neg[g]),
      .term  (term[g])
    );
  end

  always_ff @(posedge clk) begin
    x_dly[0]    <= s3_x;
    y_dly[0]    <= s3_y;
    diamond_dly <= {diamond_dly[INTERP_LAT-2:0], s3_diamond};
    for (int i = 1; i < INTERP_LAT; i++) begin
      x_dly[i] <= x_dly[i-1];
      y_dly[i] <= y_dly[i-1];
    end
  end

  // shifted position and interpolated opening
  always_ff @(posedge clk) begin
    s7_u       <= WIDE_BITS'(x_dly[INTERP_LAT-1]) + term[TERM_OX] - WIDE_BITS'(ex_h);
    s7_v       <= WIDE_BITS'(y_dly[INTERP_LAT-1]) + term[TERM_OY] - WIDE_BITS'(ey_h);
    s7_w       <= WIDE_BITS'(wen_h) + term[TERM_W];
    s7_h       <= WIDE_BITS'(hen_h) + term[TERM_H];
    s7_diamond <= diamond_dly[INTERP_LAT-1];
  end

  always_comb begin
    rot_ctl.valid   = s7_valid;
    rot_ctl.diamond = s7_diamond;
    rot_ctl.mode    = mode;
  end

  tta_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (rot_ctl),
    .u          (s7_u),
    .v          (s7_v),
    .w          (s7_w),
    .h          (s7_h),
    .cos_v      (tilt_cos_sin[TRIG_BITS-1:0]),
    .sin_v      (tilt_cos_sin[HALF_WORD +: TRIG_BITS]),
    .done       (done),
    .inside_res (inside_res)
  );
endmodule

/* rtl/core/tta_check.sv */
// port level checks for the aperture check, bound to the top level
`timescale 1ns / 1ps
module tta_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import tta_pkg::*;

  // every accepted word gives its result after the fixed latency
  a_result_follows: assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |-> ##RESULT_LATENCY done
  ) else $error("no result strobe after an accepted word");

  // no result without a word accepted at the right distance
  a_no_stray_result: assert property (
    @(posedge clk) disable iff (rst) done |-> $past(start && !busy, RESULT_LATENCY)
  ) else $error("result strobe without a matching accepted word");

  // reset empties the pipeline
  a_reset_clears: assert property (
    @(posedge clk) (!rst && $past(rst)) |-> !done
  ) else $error("result strobe straight after reset");
endmodule

bind tapered_tilted_aperture_check tta_check u_tta_check (.*);

/* test/tapered_tilted_aperture_check_tb.sv */
// testbench for the tapered tilted aperture check: directed and random position words against a predictor
`timescale 1ns / 1ps
module tapered_tilted_aperture_check_tb;
  import tta_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        z;
  } pos_word_t;

  typedef struct {
    bit        hit;
    pos_word_t w;
  } inside_expect_t;

  localparam int    TRIG_FRAC = 30;
  localparam int    RECIP_FRAC = 48;
  localparam wide_t TERM_CAP = wide_t'(1) <<< 56;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic signed [POS_BITS-1:0] pos_x = '0;
  logic signed [POS_BITS-1:0] pos_y = '0;
  logic [Z_BITS-1:0]          pos_z = '0;
  logic        done;
  logic        inside_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  // own copy of the aperture registers
  logic [1:0]  mode_q;
  logic [63:0] tilt_q;
  logic [63:0] entry_ofs_q;
  logic [63:0] exit_ofs_q;
  logic [63:0] entry_size_q;
  logic [63:0] exit_size_q;
  logic [48:0] inv_len_q;

  pos_word_t      pos_words_q[$];
  inside_expect_t inside_expect_q[$];

  bit word_taken = 1'b0;
  bit burst = 1'b0;
  int gap_left = 0;
  int words_sent = 0;
  int results_checked = 0;
  int inside_count = 0;
  int settings_used = 0;
  int errors = 0;

  tapered_tilted_aperture_check u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .done       (done),
    .inside_res (inside_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t mag_of(input wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  // linear taper along the jaw, truncated toward zero and clamped
  function automatic wide_t taper_term(input logic [30:0] z, input wide_t d);
    logic [127:0] f;
    logic [127:0] mag;
    logic [127:0] scaled;
    f = z;
    f = f * inv_len_q;
    mag = mag_of(d);
    scaled = (f * mag) >> RECIP_FRAC;
    if (scaled > TERM_CAP) scaled = TERM_CAP;
    return (d < 0) ? -$signed(scaled) : $signed(scaled);
  endfunction

  function automatic bit fits_abs(input wide_t a, input wide_t jaw);
    if (jaw <= 0) return 1'b0;
    return (2 * mag_of(a)) < (jaw <<< TRIG_FRAC);
  endfunction

  function automatic bit predict_inside(input pos_word_t w);
    wide_t x, y, c, s, ex, ey, xx, xy, wen, hen, wex, hex;
    wide_t u, v, wj, hj, a, b, sum, md;
    x = w.x;
    y = w.y;
    c = $signed(tilt_q[31:0]);
    s = $signed(tilt_q[63:32]);
    ex = $signed(entry_ofs_q[31:0]);
    ey = $signed(entry_ofs_q[63:32]);
    xx = $signed(exit_ofs_q[31:0]);
    xy = $signed(exit_ofs_q[63:32]);
    wen = entry_size_q[31:0];
    hen = entry_size_q[63:32];
    wex = exit_size_q[31:0];
    hex = exit_size_q[63:32];
    wj = wen;
    hj = hen;
    if (mode_q == MODE_TAPERED) begin
      // centred opening: diamond shortcut
      if (ex == 0 && ey == 0 && xx == 0 && xy == 0) begin
        sum = mag_of(x) + mag_of(y);
        md = (wen < hen) ? wen : hen;
        if (2 * sum < md) return 1'b1;
      end
      u = x + taper_term(w.z, ex - xx) - ex;
      v = y + taper_term(w.z, ey - xy) - ey;
      wj = wen + taper_term(w.z, wex - wen);
      hj = hen + taper_term(w.z, hex - hen);
    end else begin
      u = x - ex;
      v = y - ey;
    end
    a = u * c - v * s;
    b = u * s + v * c;
    case (mode_q)
      MODE_POS_JAW: return (a < 0 || 2 * a < (wj <<< TRIG_FRAC)) && fits_abs(b, hj);
      MODE_NEG_JAW: return (a > 0 || -2 * a < (wj <<< TRIG_FRAC)) && fits_abs(b, hj);
      default: return fits_abs(a, wj) && fits_abs(b, hj);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // driver: one position word at a time, random idle gaps
  always @(negedge clk) begin : drive
    logic      go;
    pos_word_t w;
    go = start;
    if (rst) begin
      go = 1'b0;
    end else begin
      if (start && word_taken) begin
        go = 1'b0;
        if (words_sent % 64 == 0) burst = ($urandom_range(0, 2) == 0);
        gap_left = burst ? 0 : $urandom_range(0, 8);
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pos_words_q.size() > 0) begin
          w = pos_words_q.pop_front();
          pos_x <= w.x;
          pos_y <= w.y;
          pos_z <= w.z;
          go = 1'b1;
        end
      end
    end
    start <= go;
  end

  // monitor: register copy, predictions and result check
  always @(posedge clk) begin : observe
    inside_expect_t e;
    pos_word_t      w;
    word_taken = start && !busy;
    if (rst) begin
      mode_q = MODE_TAPERED;
      tilt_q = 64'h0000_0000_4000_0000;
      entry_ofs_q = '0;
      exit_ofs_q = '0;
      entry_size_q = '0;
      exit_size_q = '0;
      inv_len_q = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:       mode_q = cfg_data[1:0];
          REG_TILT:       tilt_q = cfg_data;
          REG_ENTRY_OFS:  entry_ofs_q = cfg_data;
          REG_EXIT_OFS:   exit_ofs_q = cfg_data;
          REG_ENTRY_SIZE: entry_size_q = cfg_data;
          REG_EXIT_SIZE:  exit_size_q = cfg_data;
          REG_INV_LEN:    inv_len_q = cfg_data[48:0];
          default: ;
        endcase
      end
      if (done) begin
        if (inside_expect_q.size() == 0) begin
          report_mismatch($sformatf("result word inside_res=%b with no position pending",
                                    inside_res));
        end else begin
          e = inside_expect_q.pop_front();
          if (inside_res !== e.hit)
            report_mismatch($sformatf("x=%0d y=%0d z=%0d: inside_res %b, expected %b",
                                      e.w.x, e.w.y, e.w.z, inside_res, e.hit));
          results_checked++;
          if (e.hit) inside_count++;
        end
      end
      if (word_taken) begin
        w.x = pos_x;
        w.y = pos_y;
        w.z = pos_z;
        e.w = w;
        e.hit = predict_inside(w);
        inside_expect_q.push_back(e);
        words_sent++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [1:0] m, input logic [63:0] tilt,
                               input logic [63:0] eo, input logic [63:0] xo,
                               input logic [63:0] es, input logic [63:0] xs,
                               input logic [48:0] inv);
    write_reg(REG_MODE, {62'b0, m});
    write_reg(REG_TILT, tilt);
    write_reg(REG_ENTRY_OFS, eo);
    write_reg(REG_EXIT_OFS, xo);
    write_reg(REG_ENTRY_SIZE, es);
    write_reg(REG_EXIT_SIZE, xs);
    write_reg(REG_INV_LEN, {15'b0, inv});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_word(input logic [31:0] x, input logic [31:0] y, input logic [30:0] z);
    pos_word_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    pos_words_q.push_back(w);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pos_words_q.size() != 0 || start || inside_expect_q.size() != 0);
  endtask

  function automatic longint spread(input longint unsigned span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % (2 * span + 1)) - longint'(span);
  endfunction

  function automatic logic [63:0] rand_offsets();
    longint ox, oy;
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return {$urandom, $urandom};
      default: begin
        ox = spread(64'd65536);
        oy = spread(64'd65536);
        return {oy[31:0], ox[31:0]};
      end
    endcase
  endfunction

  function automatic logic [63:0] rand_sizes();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {32'($urandom_range(0, 1 << 18)), 32'($urandom_range(0, 1 << 18))};
    endcase
  endfunction

  // position words mostly aimed at the opening, some anywhere
  function automatic pos_word_t rand_word();
    pos_word_t       w;
    longint          cx, cy, lx, ly;
    longint unsigned span, zmax;
    w.x = $urandom;
    w.y = $urandom;
    w.z = 31'($urandom);
    if ($urandom_range(0, 7) != 0) begin
      cx = $signed(entry_ofs_q[31:0]);
      cy = $signed(entry_ofs_q[63:32]);
      if (mode_q == MODE_TAPERED && $urandom_range(0, 1) == 1) begin
        cx = $signed(exit_ofs_q[31:0]);
        cy = $signed(exit_ofs_q[63:32]);
      end
      span = (entry_size_q[31:0] + entry_size_q[63:32] + exit_size_q[31:0]
              + exit_size_q[63:32]) / 4 + 16;
      lx = cx + spread(span);
      ly = cy + spread(span);
      w.x = lx[31:0];
      w.y = ly[31:0];
      zmax = (inv_len_q == 0) ? 64'h7fff_ffff : ((64'd1 << 48) / inv_len_q) * 5 / 4;
      if (zmax > 64'h7fff_ffff) zmax = 64'h7fff_ffff;
      if ($urandom_range(0, 9) == 0)
        w.z = ($urandom_range(0, 1) == 1) ? 31'h7fff_ffff : 31'd0;
      else
        w.z = 31'($urandom_range(0, zmax[31:0]));
    end
    return w;
  endfunction

  initial begin : stimulus
    logic [63:0] tilt, es, xs, eo, xo;
    logic [48:0] inv;
    logic [31:0] c, s;
    logic [1:0]  m;
    int k, i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: closed opening
    queue_word(32'd0, 32'd0, 31'd0);
    queue_word(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    wait_idle();

    // centred opening, diamond shortcut and its edge
    apply_setting(MODE_TAPERED, 64'h0000_0000_4000_0000, '0, '0,
                  {32'd2000, 32'd1000}, {32'd500, 32'd3000}, '0);
    queue_word(32'd0, 32'd0, 31'd0);
    queue_word(-32'sd499, 32'd0, 31'd7);
    queue_word(32'd500, 32'd0, 31'd0);
    queue_word(32'd0, -32'sd999, 31'd0);
    queue_word(32'd200, 32'd200, 31'd0);
    wait_idle();

    // tilted taper closing to zero height, then extrapolated past the exit
    apply_setting(MODE_TAPERED, {32'h2d41_3ccd, 32'h2d41_3ccd},
                  {32'd100, -32'sd200}, {-32'sd300, 32'd400},
                  {32'd1000, 32'd1000}, {32'd0, 32'd2000}, 49'd281474976);
    queue_word(32'd100, -32'sd200, 31'd0);
    queue_word(-32'sd300, 32'd400, 31'd1000000);
    queue_word(32'd50, -32'sd150, 31'd500000);
    queue_word(32'd0, 32'd0, 31'h7fff_ffff);
    wait_idle();

    // extreme registers, saturated taper terms
    apply_setting(MODE_TAPERED, {32'h8000_0000, 32'h7fff_ffff},
                  {32'h7fff_ffff, 32'h8000_0000}, {32'h8000_0000, 32'h7fff_ffff},
                  '1, '0, 49'h1_0000_0000_0000);
    queue_word(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    queue_word(32'd0, 32'd0, 31'd1);
    queue_word(32'h8000_0000, 32'h7fff_ffff, 31'd0);
    wait_idle();

    // fixed opening
    apply_setting(MODE_FIXED, 64'h0000_0000_4000_0000, {32'd3000, -32'sd5000},
                  64'hffff_0000_1234_5678, {32'd2000, 32'd4000}, {32'd9, 32'd9},
                  49'h1_0000_0000_0000);
    queue_word(-32'sd5000, 32'd3000, 31'h7fff_ffff);
    queue_word(-32'sd3001, 32'd3000, 31'd0);
    queue_word(-32'sd3000, 32'd3000, 31'd0);
    wait_idle();

    // one-sided jaws
    apply_setting(MODE_POS_JAW, 64'h0000_0000_4000_0000, '0, '0,
                  {32'd1000, 32'd100}, '0, '0);
    queue_word(32'h8000_0000, 32'd0, 31'd0);
    queue_word(32'd49, 32'd0, 31'd0);
    queue_word(32'd50, 32'd0, 31'd0);
    queue_word(32'd0, 32'd500, 31'd0);
    wait_idle();
    apply_setting(MODE_NEG_JAW, 64'h0000_0000_4000_0000, '0, '0,
                  {32'd1000, 32'd100}, '0, '0);
    queue_word(32'h7fff_ffff, 32'd0, 31'd0);
    queue_word(-32'sd49, 32'd0, 31'd0);
    queue_word(-32'sd50, 32'd0, 31'd0);
    queue_word(32'd0, -32'sd499, 31'd0);
    wait_idle();

    for (k = 0; k < 12; k++) begin
      m = 2'(k % 4);
      case ($urandom_range(0, 3))
        0: tilt = 64'h0000_0000_4000_0000;
        1: begin
          c = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          s = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
          tilt = {s, c};
        end
        2: tilt = {$urandom, $urandom};
        default: tilt = ($urandom_range(0, 1) == 1) ? 64'h8000_0000_7fff_ffff
                                                    : 64'hc000_0000_0000_0000;
      endcase
      eo = rand_offsets();
      xo = rand_offsets();
      if (m == MODE_TAPERED && $urandom_range(0, 2) == 0) begin
        eo = '0;
        xo = '0;
      end
      es = rand_sizes();
      xs = rand_sizes();
      case ($urandom_range(0, 5))
        0: inv = '0;
        1: inv = 49'h1_0000_0000_0000;
        2: inv = {1'b0, 16'($urandom_range(0, 16'hffff)), $urandom};
        default: inv = 49'((64'd1 << 48) / $urandom_range(1024, 32'h7fff_ffff));
      endcase
      apply_setting(m, tilt, eo, xo, es, xs, inv);
      for (i = 0; i < 105; i++) pos_words_q.push_back(rand_word());
      wait_idle();
    end

    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (inside_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", inside_expect_q.size()));
    $display("%0d position words checked under %0d register settings, %0d inside",
             results_checked, settings_used + 1, inside_count);
    $display("all four modes, diamond shortcut, taper saturation and closed openings exercised");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timed out with %0d results outstanding", inside_expect_q.size());
    $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
rtl/core/tta_pkg.sv
rtl/core/tta_interp.sv
rtl/core/tta_rotate.sv
rtl/core/tapered_tilted_aperture_check.sv
rtl/core/tta_check.sv
test/tapered_tilted_aperture_check_tb.sv
